FILE: hdl/tkmhs_pkg.sv
// ----------------------------------------------------------------------------
// tkmhs_pkg
// Shared constants and controller/datapath handshake types for the top-k
// min-heap selector.
// ----------------------------------------------------------------------------
`default_nettype none

package tkmhs_pkg;

    localparam int K_MAX      = 64;
    localparam int VALUE_BITS = 48;
    localparam int ADDR_W     = $clog2(K_MAX);
    localparam int CNT_W      = $clog2(K_MAX + 1);
    localparam int KEEP_W     = 7;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [0:0] REG_KEEP = 1'b0;

    typedef struct packed {
        logic ins_first;
        logic ins_start;
        logic rep_start;
        logic up_step;
        logic dn_step;
        logic place;
        logic rd_up;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic ins;
        logic cnt_zero;
        logic gt_root;
        logic up_move;
        logic dn_move;
    } t_sts;

endpackage

`default_nettype wire

FILE: hdl/tkmhs_ctrl.sv
// ----------------------------------------------------------------------------
// tkmhs_ctrl
// Sequencer for insert, replace and sift walks; owns the stream handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tkmhs_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_vld,
    output logic             o_in_rdy,
    output logic             o_out_vld,
    input  wire              i_out_rdy,
    input  tkmhs_pkg::t_sts  i_sts,
    output tkmhs_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UP   = 2'd1;
    localparam logic [1:0] S_DOWN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_vld, n_out_vld;
    logic       in_acc;

    assign o_in_rdy  = (r_state == S_IDLE);
    assign o_out_vld = r_out_vld;
    assign in_acc    = i_in_vld && o_in_rdy;

    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld && !i_out_rdy;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_sts.ins && i_sts.cnt_zero) begin
                        o_cmd.ins_first = 1'b1;
                        n_state         = S_DONE;
                    end else if (i_sts.ins) begin
                        o_cmd.ins_start = 1'b1;
                        n_state         = S_UP;
                    end else if (i_sts.gt_root) begin
                        o_cmd.rep_start = 1'b1;
                        n_state         = S_DOWN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_UP: begin
                if (i_sts.up_move) begin
                    o_cmd.up_step = 1'b1;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DOWN: begin
                if (i_sts.dn_move) begin
                    o_cmd.dn_step = 1'b1;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_out_rdy) begin
                    o_cmd.out_load = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.rd_up = (n_state == S_UP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tkmhs_dp.sv
// ----------------------------------------------------------------------------
// tkmhs_dp
// Heap memory, hole position, held value, root copy, fill count and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module tkmhs_dp (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire  [tkmhs_pkg::VALUE_BITS-1:0]      i_value,
    input  wire  [tkmhs_pkg::CNT_W-1:0]           i_keep,
    input  tkmhs_pkg::t_cmd                       i_cmd,
    output tkmhs_pkg::t_sts                       o_sts,
    output logic [tkmhs_pkg::VALUE_BITS-1:0]      o_kth,
    output logic                                  o_full
);

    localparam int AW = tkmhs_pkg::ADDR_W;
    localparam int CW = tkmhs_pkg::CNT_W;
    localparam int VW = tkmhs_pkg::VALUE_BITS;

    logic [VW-1:0] mem [tkmhs_pkg::K_MAX];

    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_pos, n_pos;
    logic [VW-1:0] r_val;
    logic [VW-1:0] r_root;
    logic [VW-1:0] r_rd_a, r_rd_b;
    logic [VW-1:0] r_out;
    logic          r_full;

    logic [AW-1:0] rd_addr_a, rd_addr_b;
    logic [AW-1:0] par_pos, lch_pos, rch_pos;
    logic [AW-1:0] cur_par;
    logic [CW-1:0] lch_idx;
    logic [CW:0]   rch_idx;
    logic          l_ok, r_ok, pick_r;
    logic [VW-1:0] cval;
    logic [AW-1:0] cidx;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [VW-1:0] wr_data;
    logic          full_now;

    // read addresses follow the next hole position
    assign par_pos   = (n_pos - AW'(1)) >> 1;
    assign lch_pos   = {n_pos[AW-2:0], 1'b1};
    assign rch_pos   = lch_pos + AW'(1);
    assign rd_addr_a = i_cmd.rd_up ? par_pos : lch_pos;
    assign rd_addr_b = rch_pos;

    assign cur_par = (r_pos - AW'(1)) >> 1;
    assign lch_idx = {r_pos, 1'b1};
    assign rch_idx = {1'b0, lch_idx} + (CW + 1)'(1);
    assign l_ok    = lch_idx < r_cnt;
    assign r_ok    = rch_idx < {1'b0, r_cnt};
    assign pick_r  = r_ok && ($signed(r_rd_b) < $signed(r_rd_a));
    assign cval    = pick_r ? r_rd_b : r_rd_a;
    assign cidx    = pick_r ? rch_idx[AW-1:0] : lch_idx[AW-1:0];

    assign o_sts.ins      = r_cnt < i_keep;
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.gt_root  = $signed(i_value) > $signed(r_root);
    assign o_sts.up_move  = (r_pos != '0) && ($signed(r_rd_a) > $signed(r_val));
    assign o_sts.dn_move  = l_ok && ($signed(cval) < $signed(r_val));

    assign full_now = r_cnt >= i_keep;

    always_comb begin
        n_pos   = r_pos;
        wr_en   = 1'b0;
        wr_addr = r_pos;
        wr_data = r_val;
        if (i_cmd.ins_first) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = i_value;
        end
        if (i_cmd.ins_start) begin
            n_pos = r_cnt[AW-1:0];
        end
        if (i_cmd.rep_start) begin
            n_pos = '0;
        end
        if (i_cmd.up_step) begin
            wr_en   = 1'b1;
            wr_data = r_rd_a;
            n_pos   = cur_par;
        end
        if (i_cmd.dn_step) begin
            wr_en   = 1'b1;
            wr_data = cval;
            n_pos   = cidx;
        end
        if (i_cmd.place) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_a <= mem[rd_addr_a];
        r_rd_b <= mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (i_cmd.ins_start || i_cmd.rep_start) begin
            r_val <= i_value;
        end
        if (wr_en && (wr_addr == '0)) begin
            r_root <= wr_data;
        end
        if (i_cmd.out_load) begin
            r_full <= full_now;
            r_out  <= full_now ? r_root : '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.ins_first || i_cmd.ins_start) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    assign o_kth  = r_out;
    assign o_full = r_full;

endmodule

`default_nettype wire

FILE: hdl/top_k_min_heap_selector_top.sv
// ----------------------------------------------------------------------------
// top_k_min_heap_selector_top
// Keeps the k largest signed values seen in a min-heap and reports the kth
// largest for every word taken in.
// ----------------------------------------------------------------------------
// Usage:
//  - keep_count (k) lies at APB byte address 0; write it only while idle.
//    0 acts as 1, values above the heap depth act as the depth.
//  - Each word on s_axis gives one word on m_axis: the heap root with
//    tuser high once k values are held, else all ones with tuser low.
//  - s_axis_tready is high only while no word is in work. A word that
//    leaves the heap unchanged or lands in an empty heap goes straight to
//    the result; otherwise it sifts up or down one heap level per step.
//    The sift walk reads two entries of the single heap memory per cycle.
//  - The result lands in an output register; the next word is taken while
//    it waits. If m_axis stalls, the following result holds in the
//    sequencer and s_axis_tready stays low until the register frees.
//  - Reset empties the heap (fill count to zero), sets k to 1 and drops
//    any pending result. Heap memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_min_heap_selector_top (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire  [tkmhs_pkg::PADDR_W-1:0]         paddr,
    input  wire  [tkmhs_pkg::PDATA_W-1:0]         pwdata,
    output logic [tkmhs_pkg::PDATA_W-1:0]         prdata,
    output logic                                  pready,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire  [tkmhs_pkg::VALUE_BITS-1:0]      s_axis_tdata,  // value
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    output logic [tkmhs_pkg::VALUE_BITS-1:0]      m_axis_tdata,  // kth_largest
    output logic [0:0]                            m_axis_tuser   // full_res
);

    localparam int KW = tkmhs_pkg::KEEP_W;
    localparam int CW = tkmhs_pkg::CNT_W;

    logic [KW-1:0]   r_keep;
    logic [CW-1:0]   eff_keep;
    logic            reg_sel;
    tkmhs_pkg::t_cmd cmd;
    tkmhs_pkg::t_sts sts;
    logic            full_res;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[tkmhs_pkg::PADDR_W-1] == tkmhs_pkg::REG_KEEP);
    assign prdata  = reg_sel ? tkmhs_pkg::PDATA_W'(r_keep) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= KW'(1);
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_keep <= pwdata[KW-1:0];
        end
    end

    always_comb begin
        if (r_keep == '0) begin
            eff_keep = CW'(1);
        end else if (32'(r_keep) > tkmhs_pkg::K_MAX) begin
            eff_keep = CW'(tkmhs_pkg::K_MAX);
        end else begin
            eff_keep = CW'(r_keep);
        end
    end

    tkmhs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_vld  (s_axis_tvalid),
        .o_in_rdy  (s_axis_tready),
        .o_out_vld (m_axis_tvalid),
        .i_out_rdy (m_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    tkmhs_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_value (s_axis_tdata),
        .i_keep  (eff_keep),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_kth   (m_axis_tdata),
        .o_full  (full_res)
    );

    assign m_axis_tuser = full_res;

endmodule

`default_nettype wire
